>>> hw/rtl/hwt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwt_pkg
// shared types and constants of the hashed timer wheel
// ----------------------------------------------------------------------------
package hwt_pkg;

  localparam int unsigned TimeBits   = 48;
  localparam int unsigned PoolSize   = 32;
  localparam int unsigned EntryBits  = 5;
  localparam int unsigned LinkBits   = EntryBits + 1;
  localparam int unsigned WheelSlots = 256;
  localparam int unsigned SlotBits   = 8;
  localparam int unsigned IvBits     = 21;
  localparam int unsigned VisitBits  = SlotBits + 1;

  typedef logic [TimeBits-1:0]  time_t;
  typedef logic [IvBits-1:0]    iv_t;
  typedef logic [EntryBits-1:0] entry_t;
  typedef logic [LinkBits-1:0]  link_t;
  typedef logic [SlotBits-1:0]  slot_t;

  // end of list marker: top bit of a link set
  localparam link_t NoEntry = link_t'(PoolSize);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    RPT_ADDED       = 3'd0,
    RPT_ADD_FAIL    = 3'd1,
    RPT_CANCELLED   = 3'd2,
    RPT_CANCEL_FAIL = 3'd3,
    RPT_FIRED       = 3'd4,
    RPT_DONE        = 3'd5
  } report_t;

  localparam logic [2:0] RegTickInterval = 3'd0;
  localparam iv_t IntervalReset = iv_t'(1000);

endpackage
`default_nettype wire

>>> hw/rtl/hwt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwt_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module hwt_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/hwt_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hwt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hwt_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire hwt_pkg::time_t dividend,
  input  wire hwt_pkg::iv_t  divisor,
  output      logic          done,
  output      hwt_pkg::time_t quot,
  output      hwt_pkg::iv_t  rem
);
  import hwt_pkg::*;

  localparam int unsigned CntBits = $clog2(TimeBits + 1);

  logic [CntBits-1:0] cnt;
  logic               busy;
  logic [IvBits:0]    trial;
  logic               fits;

  assign trial = {rem, quot[TimeBits-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntBits'(TimeBits);
        quot <= dividend;
        rem  <= '0;
      end else if (busy) begin
        if (fits) begin
          rem <= IvBits'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[IvBits-1:0];
        end
        quot <= {quot[TimeBits-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CntBits'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/hashed_timer_wheel_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_timer_wheel_core
// timer wheel of 256 slots over a pool of 32 timer entries
// ----------------------------------------------------------------------------
// One word in at a time: add (1 report), cancel (1 report) or tick (fired
// reports, then a done report with last set). An add or a cancel passes
// through S_DISPATCH, which waits for a free output register, before the
// next word can be taken. A tick runs through one shared 48-bit restoring
// divider (one quotient bit per cycle): each armed pending entry is divided
// and filed into the wheel and each cancelled one freed, the elapsed time is
// divided for the advance, then slots are visited (at most 256) and each
// occupied slot is drained entry by entry; the result side can stall it.
// The slot head/tail ram is read and written through a single port each,
// and per-slot occupancy flags reset at once, so no clearing pass is needed.
// in_stall is high while a word is at work.
// ----------------------------------------------------------------------------
module hashed_timer_wheel_core (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // input words
  input  wire logic                     in_valid,
  output      logic                     in_stall,
  input  wire logic [1:0]               req_type,
  input  wire logic [47:0]              deadline_usec,
  input  wire logic [4:0]               entry_id,
  input  wire logic [47:0]              tick_time,
  // result words
  output      logic                     out_valid,
  input  wire logic                     out_stall,
  output      logic [2:0]               report_kind,
  output      logic [4:0]               timer_id,
  output      logic                     last,
  // configuration
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [2:0]               paddr,
  input  wire logic [31:0]              pwdata,
  output      logic [31:0]              prdata,
  output      logic                     pready
);
  import hwt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_TSTART, S_PEND, S_PDIV, S_PRD, S_PPUSH,
    S_ADV, S_AWAIT, S_VISIT, S_VHEAD, S_WALK, S_DONE
  } state_t;

  state_t state;

  // configuration register
  iv_t tick_interval;
  iv_t iv;
  assign pready = 1'b1;
  assign iv = (tick_interval == '0) ? iv_t'(1) : tick_interval;
  assign prdata = (paddr == RegTickInterval) ? {{(32-IvBits){1'b0}}, tick_interval} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_interval <= IntervalReset;
    end else if (psel && penable && pwrite && pready && paddr == RegTickInterval) begin
      tick_interval <= pwdata[IvBits-1:0];
    end
  end

  // latched input word
  logic [1:0] req_q;
  time_t      dl_q;
  entry_t     id_q;
  time_t      now_q;

  // entry pool
  link_t                link_next [PoolSize];
  time_t                entry_deadline [PoolSize];
  logic [PoolSize-1:0]  armed;
  logic [PoolSize-1:0]  used;
  link_t                pend_head;
  link_t                pend_tail;

  // wheel
  logic [WheelSlots-1:0] slot_busy;
  time_t                 wheel_time;
  slot_t                 wheel_pos;
  logic                  started;

  // walk registers
  link_t                 cur;
  link_t                 nxt;
  slot_t                 slot_idx;
  logic [VisitBits-1:0]  visit_cnt;
  logic [VisitBits-1:0]  visits;

  // lowest free entry
  logic   free_found;
  entry_t free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = PoolSize - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = entry_t'(i);
      end
    end
  end

  // shared divider
  logic  div_start;
  time_t div_dividend;
  logic  div_done;
  time_t div_quot;
  iv_t   div_rem;

  hwt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (iv),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  entry_t cur_e;
  time_t  cur_dl;
  assign cur_e  = cur[EntryBits-1:0];
  assign cur_dl = entry_deadline[cur_e];

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    if (state == S_PEND && !cur[LinkBits-1] && armed[cur_e]) begin
      div_start    = 1'b1;
      div_dividend = (cur_dl > wheel_time) ? cur_dl - wheel_time : '0;
    end else if (state == S_ADV && now_q >= wheel_time) begin
      div_start    = 1'b1;
      div_dividend = now_q - wheel_time;
    end
  end

  // slot ram: {head, tail}
  slot_t                    visit_slot;
  slot_t                    ram_raddr;
  logic                     ram_we;
  logic [2*EntryBits-1:0]   ram_wdata;
  logic [2*EntryBits-1:0]   ram_rdata;
  entry_t                   ram_head;
  entry_t                   ram_tail;

  assign visit_slot = wheel_pos + visit_cnt[SlotBits-1:0];
  assign ram_raddr  = (state == S_VISIT) ? visit_slot : slot_idx;
  assign ram_head   = ram_rdata[2*EntryBits-1:EntryBits];
  assign ram_tail   = ram_rdata[EntryBits-1:0];
  assign ram_we     = (state == S_PPUSH);
  assign ram_wdata  = slot_busy[slot_idx] ? {ram_head, cur_e} : {cur_e, cur_e};

  hwt_ram #(
    .WIDTH (2 * EntryBits),
    .DEPTH (WheelSlots)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register free to take a word
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      armed      <= '0;
      used       <= '0;
      pend_head  <= NoEntry;
      pend_tail  <= NoEntry;
      slot_busy  <= '0;
      wheel_time <= '0;
      wheel_pos  <= '0;
      started    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_q <= req_type;
            dl_q  <= deadline_usec;
            id_q  <= entry_id;
            now_q <= tick_time;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          priority if (req_q == REQ_TICK) begin
            state <= S_TSTART;
          end else if (req_q == REQ_NONE) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_valid <= 1'b1;
            last      <= 1'b1;
            state     <= S_IDLE;
            if (req_q == REQ_ADD) begin
              if (free_found) begin
                used[free_idx]           <= 1'b1;
                armed[free_idx]          <= 1'b1;
                entry_deadline[free_idx] <= dl_q;
                link_next[free_idx]      <= NoEntry;
                if (pend_head[LinkBits-1]) begin
                  pend_head <= {1'b0, free_idx};
                end else begin
                  link_next[pend_tail[EntryBits-1:0]] <= {1'b0, free_idx};
                end
                pend_tail   <= {1'b0, free_idx};
                report_kind <= RPT_ADDED;
                timer_id    <= free_idx;
              end else begin
                report_kind <= RPT_ADD_FAIL;
                timer_id    <= '0;
              end
            end else begin
              if (used[id_q] && armed[id_q]) begin
                armed[id_q] <= 1'b0;
                report_kind <= RPT_CANCELLED;
                timer_id    <= id_q;
              end else begin
                report_kind <= RPT_CANCEL_FAIL;
                timer_id    <= '0;
              end
            end
          end
        end
        S_TSTART: begin
          if (!started) begin
            wheel_time <= now_q;
            started    <= 1'b1;
          end
          cur   <= pend_head;
          state <= S_PEND;
        end
        // file pending entries into the wheel, freeing cancelled ones
        S_PEND: begin
          if (cur[LinkBits-1]) begin
            pend_head <= NoEntry;
            pend_tail <= NoEntry;
            state     <= S_ADV;
          end else begin
            nxt <= link_next[cur_e];
            if (!armed[cur_e]) begin
              used[cur_e] <= 1'b0;
              cur         <= link_next[cur_e];
            end else begin
              state <= S_PDIV;
            end
          end
        end
        S_PDIV: begin
          if (div_done) begin
            slot_idx <= wheel_pos + div_quot[SlotBits-1:0] + slot_t'(1);
            state    <= S_PRD;
          end
        end
        S_PRD: begin
          state <= S_PPUSH;
        end
        S_PPUSH: begin
          link_next[cur_e] <= NoEntry;
          if (slot_busy[slot_idx]) begin
            link_next[ram_tail] <= cur;
          end
          slot_busy[slot_idx] <= 1'b1;
          cur   <= nxt;
          state <= S_PEND;
        end
        // advance over elapsed intervals
        S_ADV: begin
          if (now_q >= wheel_time) begin
            state <= S_AWAIT;
          end else begin
            state <= S_DONE;
          end
        end
        S_AWAIT: begin
          if (div_done) begin
            if (div_quot >= time_t'(WheelSlots)) begin
              visits <= VisitBits'(WheelSlots);
            end else begin
              visits <= div_quot[VisitBits-1:0];
            end
            visit_cnt <= VisitBits'(1);
            state     <= S_VISIT;
          end
        end
        S_VISIT: begin
          if (visit_cnt > visits) begin
            wheel_pos  <= wheel_pos + div_quot[SlotBits-1:0];
            wheel_time <= now_q - {{(TimeBits-IvBits){1'b0}}, div_rem};
            state      <= S_DONE;
          end else if (slot_busy[visit_slot]) begin
            slot_idx <= visit_slot;
            state    <= S_VHEAD;
          end else begin
            visit_cnt <= visit_cnt + 1'b1;
          end
        end
        S_VHEAD: begin
          cur                 <= {1'b0, ram_head};
          slot_busy[slot_idx] <= 1'b0;
          visit_cnt           <= visit_cnt + 1'b1;
          state               <= S_WALK;
        end
        // drain one slot list
        S_WALK: begin
          if (cur[LinkBits-1]) begin
            state <= S_VISIT;
          end else if (!armed[cur_e]) begin
            used[cur_e] <= 1'b0;
            cur         <= link_next[cur_e];
          end else if (out_free) begin
            out_valid    <= 1'b1;
            report_kind  <= RPT_FIRED;
            timer_id     <= cur_e;
            last         <= 1'b0;
            used[cur_e]  <= 1'b0;
            armed[cur_e] <= 1'b0;
            cur          <= link_next[cur_e];
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            report_kind <= RPT_DONE;
            timer_id    <= '0;
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the hashed timer wheel core
// ----------------------------------------------------------------------------
// Drives add, cancel and tick words through a directed table and then random
// phases at several tick intervals. A behavioral model of the wheel in the
// bench predicts every report word, and each accepted report word is checked
// against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import hwt_pkg::*;

  localparam longint unsigned TimeMask = 64'h0000_FFFF_FFFF_FFFF;
  localparam int RunWords = 25;

  // one report word as predicted
  typedef struct packed {
    report_t kind;
    entry_t  id;
    logic    fin;
  } report_word_t;

  // one row of the directed table
  typedef struct {
    req_t    req;
    time_t   dl;
    entry_t  id;
    time_t   now;
    bit      chk;
    report_t ek;
    entry_t  eid;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] req_type = '0;
  logic [47:0] deadline_usec = '0;
  logic [4:0] entry_id = '0;
  logic [47:0] tick_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] report_kind;
  logic [4:0] timer_id;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // wheel model state
  link_t           m_slot_head [WheelSlots];
  link_t           m_slot_tail [WheelSlots];
  link_t           m_link [PoolSize];
  longint unsigned m_deadline [PoolSize];
  bit              m_armed [PoolSize];
  bit              m_used [PoolSize];
  link_t           m_pend_head;
  link_t           m_pend_tail;
  longint unsigned m_wheel_time;
  int unsigned     m_position;
  bit              m_started;
  iv_t             m_interval;

  report_word_t report_q[$];
  int  mismatches = 0;
  bit  failed = 1'b0;
  bit  calm = 1'b0;

  table_row_t dir_table[] = '{
    '{REQ_CANCEL, 48'd0, 5'd0, 48'd0, 1'b1, RPT_CANCEL_FAIL, 5'd0},    // cancel of a free entry
    '{REQ_TICK, 48'd0, 5'd0, 48'd0, 1'b1, RPT_DONE, 5'd0},             // first tick latches start
    '{REQ_ADD, 48'd0, 5'd0, 48'd0, 1'b1, RPT_ADDED, 5'd0},
    '{REQ_ADD, 48'hFFFF_FFFF_FFFF, 5'd0, 48'd0, 1'b1, RPT_ADDED, 5'd1},
    '{REQ_ADD, 48'd2500, 5'd0, 48'd0, 1'b1, RPT_ADDED, 5'd2},
    '{REQ_CANCEL, 48'd0, 5'd1, 48'd0, 1'b1, RPT_CANCELLED, 5'd1},
    '{REQ_CANCEL, 48'd0, 5'd1, 48'd0, 1'b1, RPT_CANCEL_FAIL, 5'd0},    // already cancelled
    '{REQ_CANCEL, 48'd0, 5'd31, 48'd0, 1'b1, RPT_CANCEL_FAIL, 5'd0},
    '{REQ_NONE, 48'hFFFF_FFFF_FFFF, 5'd31, 48'hFFFF_FFFF_FFFF, 1'b0, RPT_DONE, 5'd0},
    '{REQ_TICK, 48'd0, 5'd0, 48'd3000, 1'b0, RPT_DONE, 5'd0},
    '{REQ_TICK, 48'd0, 5'd0, 48'd1000, 1'b1, RPT_DONE, 5'd0},          // time went backwards
    '{REQ_ADD, 48'd5000, 5'd0, 48'd0, 1'b0, RPT_ADDED, 5'd0},
    '{REQ_ADD, 48'd9000, 5'd0, 48'd0, 1'b0, RPT_ADDED, 5'd0},
    '{REQ_TICK, 48'd0, 5'd0, 48'hFFFF_FFFF_FFFF, 1'b0, RPT_DONE, 5'd0}, // long gap
    '{REQ_ADD, 48'd123456789, 5'd0, 48'd0, 1'b0, RPT_ADDED, 5'd0},
    '{REQ_CANCEL, 48'd0, 5'd0, 48'd0, 1'b0, RPT_CANCELLED, 5'd0},
    '{REQ_TICK, 48'd0, 5'd0, 48'd0, 1'b0, RPT_DONE, 5'd0}              // behind the wheel again
  };

  hashed_timer_wheel_core uut (
    .clk, .rst, .in_valid, .in_stall, .req_type, .deadline_usec, .entry_id, .tick_time,
    .out_valid, .out_stall, .report_kind, .timer_id, .last,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // wheel model
  // ---------------------------------------------------------------------------
  function automatic void wheel_clear();
    for (int i = 0; i < WheelSlots; i++) begin
      m_slot_head[i] = NoEntry;
      m_slot_tail[i] = NoEntry;
    end
    for (int i = 0; i < PoolSize; i++) begin
      m_link[i] = '0;
      m_deadline[i] = 0;
      m_armed[i] = 1'b0;
      m_used[i] = 1'b0;
    end
    m_pend_head = NoEntry;
    m_pend_tail = NoEntry;
    m_wheel_time = 0;
    m_position = 0;
    m_started = 1'b0;
    m_interval = IntervalReset;
  endfunction

  function automatic void push_report(report_t kind, int unsigned id);
    report_word_t w;
    w.kind = kind;
    w.id = entry_t'(id);
    w.fin = 1'b0;
    report_q.push_back(w);
  endfunction

  // runs one tick through the model, queueing fired reports and the done
  function automatic void wheel_tick(longint unsigned now);
    longint unsigned iv, d, steps, visits, step;
    int unsigned e, nx, s, n;
    iv = (m_interval == 0) ? 1 : longint'(m_interval);
    n = 0;
    if (!m_started) begin
      m_wheel_time = now;
      m_started = 1'b1;
    end
    // file pending entries, dropping cancelled ones
    e = m_pend_head;
    while (e < PoolSize) begin
      nx = m_link[e];
      if (!m_armed[e]) begin
        m_used[e] = 1'b0;
      end else begin
        d = (m_deadline[e] > m_wheel_time) ? m_deadline[e] - m_wheel_time : 0;
        step = (d / iv + 1) % WheelSlots;
        s = 32'((m_position + step) % WheelSlots);
        m_link[e] = NoEntry;
        if (m_slot_head[s] == NoEntry) m_slot_head[s] = link_t'(e);
        else m_link[m_slot_tail[s]] = link_t'(e);
        m_slot_tail[s] = link_t'(e);
      end
      e = nx;
    end
    m_pend_head = NoEntry;
    m_pend_tail = NoEntry;
    // advance, visiting at most one revolution
    if (now >= m_wheel_time) begin
      steps = (now - m_wheel_time) / iv;
      visits = (steps < WheelSlots) ? steps : WheelSlots;
      for (longint unsigned v = 1; v <= visits; v++) begin
        s = 32'((m_position + v) % WheelSlots);
        e = m_slot_head[s];
        while (e < PoolSize) begin
          nx = m_link[e];
          if (m_armed[e] && n < PoolSize) begin
            push_report(RPT_FIRED, e);
            n++;
          end
          m_used[e] = 1'b0;
          m_armed[e] = 1'b0;
          e = nx;
        end
        m_slot_head[s] = NoEntry;
        m_slot_tail[s] = NoEntry;
      end
      m_position = 32'((m_position + steps % WheelSlots) % WheelSlots);
      m_wheel_time = (m_wheel_time + steps * iv) & TimeMask;
    end
    push_report(RPT_DONE, 0);
  endfunction

  // predicts the reports of one accepted word; returns how many were queued
  function automatic int predict_reports(req_t req, time_t dl, entry_t id, time_t now);
    int before_n;
    int unsigned e;
    before_n = report_q.size();
    case (req)
      REQ_ADD: begin
        e = PoolSize;
        for (int i = PoolSize - 1; i >= 0; i--) if (!m_used[i]) e = unsigned'(i);
        if (e == PoolSize) begin
          push_report(RPT_ADD_FAIL, 0);
        end else begin
          m_used[e] = 1'b1;
          m_armed[e] = 1'b1;
          m_deadline[e] = 64'(dl);
          m_link[e] = NoEntry;
          if (m_pend_head == NoEntry) m_pend_head = link_t'(e);
          else m_link[m_pend_tail] = link_t'(e);
          m_pend_tail = link_t'(e);
          push_report(RPT_ADDED, e);
        end
      end
      REQ_CANCEL: begin
        if (m_used[id] && m_armed[id]) begin
          m_armed[id] = 1'b0;
          push_report(RPT_CANCELLED, id);
        end else begin
          push_report(RPT_CANCEL_FAIL, 0);
        end
      end
      REQ_TICK: wheel_tick(64'(now));
      default: ;
    endcase
    if (report_q.size() > before_n) report_q[report_q.size() - 1].fin = 1'b1;
    return report_q.size() - before_n;
  endfunction

  // ---------------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------------
  // sends one word; called and returning at a falling edge; head is the
  // first report predicted for it
  task automatic send_word(req_t req, time_t dl, entry_t id, time_t now,
                           output report_word_t head);
    int gap;
    int n;
    gap = (!calm && $urandom_range(99) < 15) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type = req;
    deadline_usec = dl;
    entry_id = id;
    tick_time = now;
    in_valid = 1'b1;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
      @(negedge clk);
    end
    n = predict_reports(req, dl, id, now);
    head = '0;
    if (n > 0) head = report_q[report_q.size() - n];
    @(negedge clk);
  endtask

  // waits for every predicted report, then lets the core settle
  task automatic drain();
    in_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_interval(iv_t value);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(RegTickInterval * 4);
    pwdata = 32'(value);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    m_interval = value;
  endtask

  task automatic check_interval();
    psel = 1'b1;
    pwrite = 1'b0;
    penable = 1'b0;
    paddr = 3'(RegTickInterval * 4);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[IvBits-1:0] !== m_interval) begin
      failed = 1'b1;
      $display("interval readback: expected %0d got %0d", m_interval, prdata[IvBits-1:0]);
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // random deadline, mostly within reach of the wheel
  function automatic time_t pick_deadline();
    longint unsigned iv;
    int unsigned pick;
    iv = (m_interval == 0) ? 1 : longint'(m_interval);
    pick = $urandom_range(99);
    if (pick < 70)
      return time_t'(m_wheel_time + longint'($urandom_range(300)) * iv +
                     $urandom_range(32'(iv - 1)));
    else if (pick < 80)
      return time_t'(m_wheel_time - $urandom_range(5000));
    return time_t'({$urandom, $urandom});
  endfunction

  // random tick time: mostly short steps, some long gaps and some backwards
  function automatic time_t pick_now();
    longint unsigned iv;
    int unsigned pick;
    iv = (m_interval == 0) ? 1 : longint'(m_interval);
    pick = $urandom_range(99);
    if (pick < 65)
      return time_t'(m_wheel_time + longint'($urandom_range(20)) * iv +
                     $urandom_range(32'(iv - 1)));
    else if (pick < 77)
      return time_t'(m_wheel_time - $urandom_range(1, 3000));
    else if (pick < 90)
      return time_t'(m_wheel_time + longint'($urandom_range(256, 5000)) * iv);
    return time_t'({$urandom, $urandom});
  endfunction

  task automatic random_words(int count, bit burst);
    report_word_t head;
    int pick;
    req_t req;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (burst || pick < 45) req = REQ_ADD;
      else if (pick < 65) req = REQ_CANCEL;
      else if (pick < 95) req = REQ_TICK;
      else req = REQ_NONE;
      send_word(req, pick_deadline(), entry_t'($urandom), pick_now(), head);
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking of report words
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 15);
  end

  always @(posedge clk) begin
    report_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        failed = 1'b1;
        if (mismatches < 10)
          $display("unexpected report: kind %0d id %0d last %0b", report_kind, timer_id, last);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        if (report_kind !== want.kind || timer_id !== want.id || last !== want.fin) begin
          failed = 1'b1;
          if (mismatches < 10)
            $display("report mismatch: expected kind %0d id %0d last %0b, got %0d %0d %0b",
                     want.kind, want.id, want.fin, report_kind, timer_id, last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    report_word_t head;
    iv_t settings[] = '{21'd0, 21'd1, 21'd1048576, 21'h1FFFFF, 21'd37, 21'd1000};
    wheel_clear();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    check_interval();

    // directed table, reset interval
    foreach (dir_table[i]) begin
      send_word(dir_table[i].req, dir_table[i].dl, dir_table[i].id, dir_table[i].now, head);
      if (dir_table[i].chk &&
          (head.kind != dir_table[i].ek || head.id != dir_table[i].eid)) begin
        failed = 1'b1;
        $display("table row %0d: expected kind %0d id %0d, model has %0d %0d", i,
                 dir_table[i].ek, dir_table[i].eid, head.kind, head.id);
      end
    end
    random_words(RunWords, 1'b0);

    // one phase per interval setting, the core idle at each write
    foreach (settings[p]) begin
      drain();
      write_interval(settings[p]);
      check_interval();
      if (p == 2) calm = 1'b1;
      if (p == 4) begin
        random_words(36, 1'b1);   // overfill the pool
        random_words(5, 1'b0);
      end else begin
        random_words(RunWords, 1'b0);
      end
      calm = 1'b0;
    end

    in_valid = 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (!failed && mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
